### sv/gppm_pkg.sv
// Shared types and constants for the ground plane perspective map.
// No dependencies; every other file imports this package.
`default_nettype none
package gppm_pkg;

	localparam int ROW_W = 11;
	localparam int COL_W = 11;
	localparam int Q_W   = 32;
	localparam int MAG_W = 44;            // |X|, |Y|, clamped Z
	localparam int SUM_W = MAG_W + 1;     // signed affine sum
	localparam int NUM_W = MAG_W + 16;    // dividend |X| << 16, also quotient width
	localparam int PRD_W = 44;            // coefficient times pixel index
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_X_COEF    = 3'd0;
	localparam logic [IDX_W-1:0] REG_Y_COEF    = 3'd1;
	localparam logic [IDX_W-1:0] REG_Z_COEF    = 3'd2;
	localparam logic [IDX_W-1:0] REG_XY_OFFSET = 3'd3;
	localparam logic [IDX_W-1:0] REG_Z_OFFSET  = 3'd4;
	localparam logic [IDX_W-1:0] REG_FOCAL     = 3'd5;
	localparam logic [IDX_W-1:0] REG_CENTRE    = 3'd6;

	typedef struct packed {
		logic [63:0] x_coef;
		logic [63:0] y_coef;
		logic [63:0] z_coef;
		logic [63:0] xy_offset;
		logic [31:0] z_offset;
		logic [63:0] focal;
		logic [63:0] centre;
	} cfg_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [NUM_W-1:0] nq;    // dividend bits shift out, quotient bits shift in
	} div_lane_t;

	typedef struct packed {
		div_lane_t        x;
		div_lane_t        y;
		logic [MAG_W-1:0] den;
		logic             neg_x;
		logic             neg_y;
	} div_item_t;

endpackage
`default_nettype wire

### sv/gppm_pix_if.sv
// Input channel: one output pixel position per item.
// Depends on gppm_pkg.
`default_nettype none
interface gppm_pix_if;
	import gppm_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	modport source (output valid, output row, output col, input ready);
	modport sink (input valid, input row, input col, output ready);
endinterface
`default_nettype wire

### sv/gppm_map_if.sv
// Output channel: one source coordinate pair per item.
// Depends on gppm_pkg.
`default_nettype none
interface gppm_map_if;
	import gppm_pkg::*;
	logic           valid;
	logic           ready;
	logic [Q_W-1:0] src_u;
	logic [Q_W-1:0] src_v;
	logic           saturated;
	modport source (output valid, output src_u, output src_v, output saturated, input ready);
	modport sink (input valid, input src_u, input src_v, input saturated, output ready);
endinterface
`default_nettype wire

### sv/gppm_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on gppm_pkg.
`default_nettype none
interface gppm_cfg_if;
	import gppm_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [63:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/gppm_affine.sv
// Front end: clamp row/column, form camera X, Y, Z, take magnitudes.
// Two register stages. Depends on gppm_pkg.
`default_nettype none
module gppm_affine #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire gppm_pkg::cfg_t            cfg,
	input  wire logic [gppm_pkg::ROW_W-1:0] row,
	input  wire logic [gppm_pkg::COL_W-1:0] col,
	output gppm_pkg::div_item_t            item
);
	import gppm_pkg::*;

	localparam logic [12:0] ROW_LAST = 13'(MAX_HEIGHT - 1);
	localparam logic [12:0] COL_LAST = 13'(MAX_WIDTH - 1);

	logic [ROW_W-1:0] row_c;
	logic [COL_W-1:0] col_c;
	logic signed [PRD_W-1:0] xr_s1, xc_s1, yr_s1, yc_s1, zr_s1, zc_s1;
	logic signed [SUM_W-1:0] sx, sy, sz;
	div_item_t item_s2;

	always_comb begin
		row_c = (13'(row) > ROW_LAST) ? ROW_LAST[ROW_W-1:0] : row;
		col_c = (13'(col) > COL_LAST) ? COL_LAST[COL_W-1:0] : col;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s1 <= $signed(cfg.x_coef[63:32]) * $signed({1'b0, row_c});
			xc_s1 <= $signed(cfg.x_coef[31:0])  * $signed({1'b0, col_c});
			yr_s1 <= $signed(cfg.y_coef[63:32]) * $signed({1'b0, row_c});
			yc_s1 <= $signed(cfg.y_coef[31:0])  * $signed({1'b0, col_c});
			zr_s1 <= $signed(cfg.z_coef[63:32]) * $signed({1'b0, row_c});
			zc_s1 <= $signed(cfg.z_coef[31:0])  * $signed({1'b0, col_c});
		end
	end

	always_comb begin
		sx = SUM_W'($signed(cfg.xy_offset[63:32])) + SUM_W'(xr_s1) + SUM_W'(xc_s1);
		sy = SUM_W'($signed(cfg.xy_offset[31:0])) + SUM_W'(yr_s1) + SUM_W'(yc_s1);
		sz = SUM_W'($signed(cfg.z_offset)) + SUM_W'(zr_s1) + SUM_W'(zc_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.neg_x <= sx[SUM_W-1];
			item_s2.neg_y <= sy[SUM_W-1];
			item_s2.x.rem <= '0;
			item_s2.y.rem <= '0;
			item_s2.x.nq  <= {(sx[SUM_W-1] ? MAG_W'(-sx) : sx[MAG_W-1:0]), 16'b0};
			item_s2.y.nq  <= {(sy[SUM_W-1] ? MAG_W'(-sy) : sy[MAG_W-1:0]), 16'b0};
			// clamp depth to one LSB
			item_s2.den   <= (sz < SUM_W'(1)) ? MAG_W'(1) : sz[MAG_W-1:0];
		end
	end

	assign item = item_s2;
endmodule
`default_nettype wire

### sv/gppm_div_cell.sv
// One restoring-division cell: resolves one quotient bit for X and Y.
// Depends on gppm_pkg.
`default_nettype none
module gppm_div_cell (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire gppm_pkg::div_item_t d_in,
	output gppm_pkg::div_item_t      d_out
);
	import gppm_pkg::*;

	function automatic div_lane_t step(input div_lane_t l, input logic [MAG_W-1:0] den);
		logic [MAG_W:0] t;
		logic           q;
		div_lane_t      r;
		t = {l.rem, l.nq[NUM_W-1]};
		q = (t >= {1'b0, den});
		r.rem = q ? MAG_W'(t - {1'b0, den}) : t[MAG_W-1:0];
		r.nq  = {l.nq[NUM_W-2:0], q};
		return r;
	endfunction

	div_item_t item_q;

	always_ff @(posedge clk) begin
		if (en) begin
			item_q.x     <= step(d_in.x, d_in.den);
			item_q.y     <= step(d_in.y, d_in.den);
			item_q.den   <= d_in.den;
			item_q.neg_x <= d_in.neg_x;
			item_q.neg_y <= d_in.neg_y;
		end
	end

	assign d_out = item_q;
endmodule
`default_nettype wire

### sv/gppm_scale.sv
// Back end for one axis: scale ratio by focal length, add centre, saturate.
// Two register stages. Depends on gppm_pkg.
`default_nettype none
module gppm_scale (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [gppm_pkg::NUM_W-1:0] ratio,
	input  wire logic                      neg_num,
	input  wire logic [gppm_pkg::Q_W-1:0]   focal,
	input  wire logic [gppm_pkg::Q_W-1:0]   centre,
	output logic [gppm_pkg::Q_W-1:0]        coord,
	output logic                           sat
);
	import gppm_pkg::*;

	localparam int HI_W = NUM_W - 32;
	localparam int P_W  = 49;
	localparam int V_W  = 51;
	localparam logic signed [V_W-1:0] V_MAX = V_W'(64'sd2147483647);
	localparam logic signed [V_W-1:0] V_MIN = -V_W'(64'sd2147483648);

	logic [Q_W-1:0]      fmag;
	logic                pneg_s3;
	logic [HI_W+31:0]    phi_s3;
	logic [63:0]         plo_s3;
	logic [P_W-1:0]      p;
	logic signed [V_W-1:0] v;
	logic [Q_W-1:0]      coord_s4;
	logic                sat_s4;

	assign fmag = focal[Q_W-1] ? (~focal + 32'd1) : focal;

	always_ff @(posedge clk) begin
		if (en) begin
			pneg_s3 <= neg_num ^ focal[Q_W-1];
			phi_s3  <= ratio[NUM_W-1:32] * fmag;
			plo_s3  <= ratio[31:0] * fmag;
		end
	end

	always_comb begin
		p = P_W'({phi_s3[16:0], 16'b0}) + P_W'(plo_s3[63:16]);
		v = pneg_s3 ? -$signed({2'b0, p}) : $signed({2'b0, p});
		v = v + V_W'($signed(centre));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (phi_s3 >= (HI_W+32)'(1 << 17)) begin
				coord_s4 <= pneg_s3 ? 32'h8000_0000 : 32'h7FFF_FFFF;
				sat_s4   <= 1'b1;
			end else if (v > V_MAX) begin
				coord_s4 <= 32'h7FFF_FFFF;
				sat_s4   <= 1'b1;
			end else if (v < V_MIN) begin
				coord_s4 <= 32'h8000_0000;
				sat_s4   <= 1'b1;
			end else begin
				coord_s4 <= v[Q_W-1:0];
				sat_s4   <= 1'b0;
			end
		end
	end

	assign coord = coord_s4;
	assign sat   = sat_s4;
endmodule
`default_nettype wire

### sv/ground_plane_perspective_map.sv
// Ground plane perspective map: top-down pixel (row, col) to source (u, v).
// Pipeline: 2 affine stages, 60 division cells, 2 scaling stages.
// Throughput one item per cycle; the 60-cell restoring divider chain is
// fully pipelined and the whole pipe holds when the output item is not taken.
// Reset (arst_n low, asynchronous) clears the configuration registers and the
// valid bits, which empties the pipe; datapath registers are left unreset.
// The user must write configuration only while the pipe is empty; the block does not enforce this.
`default_nettype none
module ground_plane_perspective_map #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input wire logic clk,
	input wire logic arst_n,
	gppm_pix_if.sink   pixel,
	gppm_map_if.source coord,
	gppm_cfg_if.sink   cfg
);
	import gppm_pkg::*;

	localparam int CELLS = NUM_W;        // one quotient bit per cell
	localparam int LAT   = CELLS + 4;

	cfg_t            cfg_q;
	logic            en;
	logic [LAT-1:0]  valid_q;
	div_item_t       chain [0:CELLS];
	logic            sat_u, sat_v;

	// Configuration registers: always ready, unknown indexes dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_X_COEF:    cfg_q.x_coef    <= cfg.data;
				REG_Y_COEF:    cfg_q.y_coef    <= cfg.data;
				REG_Z_COEF:    cfg_q.z_coef    <= cfg.data;
				REG_XY_OFFSET: cfg_q.xy_offset <= cfg.data;
				REG_Z_OFFSET:  cfg_q.z_offset  <= cfg.data[31:0];
				REG_FOCAL:     cfg_q.focal     <= cfg.data;
				REG_CENTRE:    cfg_q.centre    <= cfg.data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// Advance the whole pipe unless the output item is held.
	assign en          = !valid_q[LAT-1] || coord.ready;
	assign pixel.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], pixel.valid};
		end
	end

	gppm_affine #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_affine (
		.clk (clk),
		.en  (en),
		.cfg (cfg_q),
		.row (pixel.row),
		.col (pixel.col),
		.item(chain[0])
	);

	// Divider chain: each cell shifts one quotient bit into both lanes.
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		gppm_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.d_in (chain[k]),
			.d_out(chain[k+1])
		);
	end

	gppm_scale u_scale_u (
		.clk    (clk),
		.en     (en),
		.ratio  (chain[CELLS].x.nq),
		.neg_num(chain[CELLS].neg_x),
		.focal  (cfg_q.focal[63:32]),
		.centre (cfg_q.centre[63:32]),
		.coord  (coord.src_u),
		.sat    (sat_u)
	);

	gppm_scale u_scale_v (
		.clk    (clk),
		.en     (en),
		.ratio  (chain[CELLS].y.nq),
		.neg_num(chain[CELLS].neg_y),
		.focal  (cfg_q.focal[31:0]),
		.centre (cfg_q.centre[31:0]),
		.coord  (coord.src_v),
		.sat    (sat_v)
	);

	assign coord.saturated = sat_u | sat_v;
	assign coord.valid     = valid_q[LAT-1];
endmodule
`default_nettype wire
